### rtl/core/dgb_pkg.sv
`default_nettype none
package dgb_pkg;

  localparam int WINDOW_DEF   = 8;
  localparam int GRAD_W       = 17;
  localparam int RTT_W        = 16;
  localparam int KEY_W        = 32;
  localparam int CMD_W        = 2;
  localparam int OUT_GRAD_W   = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 8;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 32;
  localparam int EXP_W        = 32;
  localparam int EXP_HI_W     = 16;
  localparam int EXP_K_W      = 5;
  localparam int X_W          = 24;

  localparam int LW_DEF        = $clog2(WINDOW_DEF);
  localparam int SUM_W_DEF     = GRAD_W + 1 + LW_DEF;
  localparam int NUM_W_DEF     = SUM_W_DEF + $clog2(WINDOW_DEF + 1);
  localparam int MUL_A_W_DEF   = (NUM_W_DEF > EXP_W) ? NUM_W_DEF : EXP_W;
  localparam int MUL_B_W       = 17;

  localparam logic [MUL_B_W-1:0]    EXP_LSB_STEP = 17'd4294;
  localparam logic [EXP_W-1:0]      EXP_FULL     = 32'hFFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] CNT_MAX      = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] FACTOR_RST   = 8'd42;
  localparam logic [CFG_DATA_W-1:0] LIMIT_RST    = 8'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_RTT         = 2'd0,
    CMD_ROUND_END   = 2'd1,
    CMD_REDUCE_EXIT = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKOFF_FACTOR = 2'd0,
    CFG_INEFF_LIMIT    = 2'd1,
    CFG_TOL_ENABLE     = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QS_UNKNOWN = 2'd0,
    QS_FULL    = 2'd1,
    QS_NONFULL = 2'd2,
    QS_BACKOFF = 2'd3
  } qstate_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_GRAD,
    S_SCALE,
    S_DIV,
    S_DEC,
    S_X,
    S_INIT,
    S_EXP,
    S_EXPW,
    S_LIM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gmin;
    logic signed [GRAD_W-1:0] gmax;
  } grad_pair_t;

  function automatic logic [MUL_B_W-1:0] exp_factor(input logic [EXP_K_W-1:0] k);
    logic [MUL_B_W-1:0] y;
    case (k)
      5'd1:    y = 17'd65519;
      5'd2:    y = 17'd65502;
      5'd3:    y = 17'd65469;
      5'd4:    y = 17'd65402;
      5'd5:    y = 17'd65268;
      5'd6:    y = 17'd65002;
      5'd7:    y = 17'd64471;
      5'd8:    y = 17'd63423;
      5'd9:    y = 17'd61379;
      5'd10:   y = 17'd57485;
      5'd11:   y = 17'd50424;
      5'd12:   y = 17'd38796;
      5'd13:   y = 17'd22966;
      5'd14:   y = 17'd8048;
      5'd15:   y = 17'd988;
      5'd16:   y = 17'd15;
      default: y = 17'd65536;
    endcase
    return y;
  endfunction

endpackage
`default_nettype wire

### rtl/core/delay_gradient_backoff.sv
// Delay-gradient congestion backoff detector. Each request carries a command in
// in_tuser: an RTT sample updates the round min/max, a reduction exit shifts the
// round into the previous round, and a round end returns one result with the
// smoothed gradient, the backoff decision and the queue state. A round end goes
// straight to the result when the round or the previous round is empty, and skips
// the exponent when the gradient is not positive. While the gradient ring is still
// filling, it adds a shift-subtract divide by the fill count (NUM_W = 19 + 2*log2
// WINDOW bits for a power-of-two WINDOW, 25 at the default WINDOW of 8). The
// exponent runs on the shared multiplier, 32x17 at the default WINDOW, one step for
// each bit of the 16-bit exponent argument up to its highest set bit and a further
// multiply for each set bit; its result is zero when the argument is cut off. Input
// is not ready while a round end is in work. The result waits in an output register,
// so the next request is taken while it is unread; a further round end holds in its
// last step until that register is read.
// Configuration writes are taken in any cycle.
`default_nettype none
module delay_gradient_backoff #(
  parameter int WINDOW = dgb_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [dgb_pkg::IN_TDATA_W-1:0]    in_tdata,   // rtt_ms, random_key
  input  wire logic [dgb_pkg::CMD_W-1:0]         in_tuser,   // command
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [dgb_pkg::OUT_TDATA_W-1:0]        out_tdata,  // gradient, backoff, queue_state
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dgb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dgb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dgb_pkg::*;

  localparam int LW    = $clog2(WINDOW);
  localparam int SUM_W = GRAD_W + 1 + LW;
  localparam int NUM_W = SUM_W + $clog2(WINDOW + 1);
  localparam int GW    = NUM_W + 1;
  localparam int A_W   = (NUM_W > EXP_W) ? NUM_W : EXP_W;
  localparam int P_W   = A_W + MUL_B_W;
  localparam int EW    = (GW > OUT_GRAD_W) ? GW : OUT_GRAD_W;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0]   factor_r;
  logic [CFG_DATA_W-1:0]   limit_r;
  logic                    tol_en_r;

  logic [RTT_W-1:0]        round_min_r, round_max_r, prev_min_r, prev_max_r;
  logic signed [SUM_W-1:0] sum_min_r, sum_max_r;
  logic [LW-1:0]           tail_r, tail_nxt;
  logic                    filled_r;
  logic                    scale_r;
  logic [CFG_DATA_W-1:0]   bcnt_r;
  qstate_t                 cdg_r;

  logic signed [GRAD_W-1:0] gmin_r, gmax_r;
  logic signed [GW-1:0]     g_r;
  logic                     neg_r;
  logic                     back_r;
  logic [KEY_W-1:0]         key_r;
  logic [EXP_W-1:0]         res_r;
  logic [EXP_HI_W-1:0]      hi_r;
  logic [EXP_K_W-1:0]       k_r;

  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  logic                     in_acc;
  cmd_t                     cmd;
  logic [RTT_W-1:0]         rtt;
  logic                     round_zero, prev_zero, out_free;

  logic                     ring_rd, ring_wr;
  grad_pair_t               ring_wdata, ring_rdata, ring_old;

  logic                     mul_en;
  logic [A_W-1:0]           mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [P_W-1:0]           mul_p;

  logic                     div_start, div_done;
  logic [NUM_W-1:0]         div_quo;

  logic                     smin_pos, smax_pos, smax_neg;
  logic signed [SUM_W-1:0]  sel;
  logic [SUM_W-1:0]         mag;
  logic                     g_pos;
  logic                     x_ovf;
  logic signed [GW-1:0]     q_ext;
  logic signed [EW-1:0]     g_ext;
  logic [OUT_GRAD_W-1:0]    g_sat;
  logic [EW-OUT_GRAD_W:0]   g_top;

  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = cmd_t'(in_tuser);
  assign rtt        = in_tdata[RTT_W-1:0];
  assign round_zero = (round_min_r == '0) && (round_max_r == '0);
  assign prev_zero  = (prev_min_r == '0) && (prev_max_r == '0);
  assign out_free   = !out_valid_r || out_tready;
  assign cfg_ready  = 1'b1;

  assign tail_nxt   = (tail_r == LW'(WINDOW - 1)) ? '0 : tail_r + 1'b1;
  assign ring_old   = filled_r ? ring_rdata : '0;
  assign ring_wdata = '{gmin: gmin_r, gmax: gmax_r};

  assign smin_pos = !sum_min_r[SUM_W-1] && (sum_min_r != '0);
  assign smax_pos = !sum_max_r[SUM_W-1] && (sum_max_r != '0);
  assign smax_neg = sum_max_r[SUM_W-1];
  assign sel      = smin_pos ? sum_min_r : sum_max_r;
  assign mag      = sel[SUM_W-1] ? SUM_W'(-sel) : SUM_W'(sel);
  assign g_pos    = !g_r[GW-1] && (g_r != '0);
  assign x_ovf    = |mul_p[P_W-1:X_W];
  assign q_ext    = {1'b0, div_quo};

  assign g_ext = EW'(g_r);
  assign g_top = g_ext[EW-1:OUT_GRAD_W-1];
  assign g_sat = ((&g_top) || !(|g_top)) ? g_ext[OUT_GRAD_W-1:0]
               : (g_ext[EW-1] ? {1'b1, {(OUT_GRAD_W-1){1'b0}}}
                              : {1'b0, {(OUT_GRAD_W-1){1'b1}}});

  dgb_ring #(.WINDOW(WINDOW)) u_ring (
    .clk   (clk),
    .rd_en (ring_rd),
    .wr_en (ring_wr),
    .addr  (tail_r),
    .wdata (ring_wdata),
    .rdata (ring_rdata)
  );

  dgb_mul #(.A_W(A_W)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dgb_div #(.NUM_W(NUM_W), .DEN_W(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_p[NUM_W-1:0]),
    .divisor  (tail_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (cmd == CMD_ROUND_END)) begin
          state_nxt = (round_zero || prev_zero) ? S_DONE : S_SUM;
        end
      end
      S_SUM:   state_nxt = S_GRAD;
      S_GRAD:  state_nxt = scale_r ? S_SCALE : S_DEC;
      S_SCALE: state_nxt = S_DIV;
      S_DIV:   state_nxt = div_done ? S_DEC : S_DIV;
      S_DEC:   state_nxt = g_pos ? S_X : S_DONE;
      S_X:     state_nxt = x_ovf ? S_EXP : S_INIT;
      S_INIT:  state_nxt = S_EXP;
      S_EXP: begin
        if (hi_r == '0) begin
          state_nxt = S_LIM;
        end else if (hi_r[0]) begin
          state_nxt = S_EXPW;
        end
      end
      S_EXPW:  state_nxt = S_EXP;
      S_LIM:   state_nxt = S_DONE;
      S_DONE:  state_nxt = out_free ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    ring_rd   = 1'b0;
    ring_wr   = 1'b0;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ring_rd   = in_acc && (cmd == CMD_ROUND_END);
      end
      S_SUM: ring_wr = 1'b1;
      S_GRAD: begin
        mul_en = scale_r;
        mul_a  = A_W'(mag);
        mul_b  = MUL_B_W'(WINDOW);
      end
      S_SCALE: div_start = 1'b1;
      S_DEC: begin
        mul_en = g_pos;
        mul_a  = A_W'(g_r[NUM_W-1:0]);
        mul_b  = MUL_B_W'(factor_r);
      end
      S_X: begin
        mul_en = !x_ovf;
        mul_a  = A_W'(mul_p[7:0]);
        mul_b  = EXP_LSB_STEP;
      end
      S_EXP: begin
        mul_en = hi_r[0];
        mul_a  = A_W'(res_r);
        mul_b  = exp_factor(k_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      factor_r    <= FACTOR_RST;
      limit_r     <= LIMIT_RST;
      tol_en_r    <= 1'b0;
      round_min_r <= '0;
      round_max_r <= '0;
      prev_min_r  <= '0;
      prev_max_r  <= '0;
      sum_min_r   <= '0;
      sum_max_r   <= '0;
      tail_r      <= '0;
      filled_r    <= 1'b0;
      scale_r     <= 1'b0;
      bcnt_r      <= '0;
      cdg_r       <= QS_UNKNOWN;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BACKOFF_FACTOR: factor_r <= cfg_data;
          CFG_INEFF_LIMIT:    limit_r  <= cfg_data;
          CFG_TOL_ENABLE:     tol_en_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            unique case (cmd)
              CMD_RTT: begin
                if ((round_min_r == '0) || (rtt < round_min_r)) begin
                  round_min_r <= rtt;
                end
                if (rtt > round_max_r) begin
                  round_max_r <= rtt;
                end
              end
              CMD_REDUCE_EXIT: begin
                cdg_r       <= QS_UNKNOWN;
                prev_min_r  <= round_min_r;
                prev_max_r  <= round_max_r;
                round_min_r <= '0;
                round_max_r <= '0;
              end
              CMD_ROUND_END: begin
                back_r <= 1'b0;
                g_r    <= '0;
                key_r  <= in_tdata[IN_TDATA_W-1:RTT_W];
                gmin_r <= {1'b0, round_min_r} - {1'b0, prev_min_r};
                gmax_r <= {1'b0, round_max_r} - {1'b0, prev_max_r};
                if (!round_zero) begin
                  prev_min_r  <= round_min_r;
                  prev_max_r  <= round_max_r;
                  round_min_r <= '0;
                  round_max_r <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          sum_min_r <= sum_min_r + SUM_W'(gmin_r) - SUM_W'(ring_old.gmin);
          sum_max_r <= sum_max_r + SUM_W'(gmax_r) - SUM_W'(ring_old.gmax);
          tail_r    <= tail_nxt;
          scale_r   <= !filled_r && (tail_nxt != '0);
          if (!filled_r && (tail_nxt == '0)) begin
            filled_r <= 1'b1;
          end
        end
        S_GRAD: begin
          g_r   <= GW'(sel);
          neg_r <= sel[SUM_W-1];
          if (!smin_pos || !smax_pos) begin
            bcnt_r <= '0;
          end
          if (tol_en_r) begin
            if (smin_pos && !smax_pos) begin
              cdg_r <= QS_FULL;
            end else if ((smin_pos && smax_pos) || smax_neg) begin
              cdg_r <= QS_NONFULL;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            g_r <= neg_r ? -q_ext : q_ext;
          end
        end
        S_X: begin
          k_r <= EXP_K_W'(1);
          if (x_ovf) begin
            res_r <= '0;
            hi_r  <= '0;
          end else begin
            hi_r <= mul_p[X_W-1:8];
          end
        end
        S_INIT: res_r <= EXP_FULL - mul_p[EXP_W-1:0];
        S_EXP: begin
          if ((hi_r != '0) && !hi_r[0]) begin
            hi_r <= hi_r >> 1;
            k_r  <= k_r + 1'b1;
          end
        end
        S_EXPW: begin
          res_r <= mul_p[EXP_W+15:16];
          hi_r  <= hi_r >> 1;
          k_r   <= k_r + 1'b1;
        end
        S_LIM: begin
          if (key_r > res_r) begin
            if (limit_r != '0) begin
              if (bcnt_r != CNT_MAX) begin
                bcnt_r <= bcnt_r + 1'b1;
              end
              if (bcnt_r < limit_r) begin
                back_r <= 1'b1;
                cdg_r  <= QS_BACKOFF;
              end
            end else begin
              back_r <= 1'b1;
              cdg_r  <= QS_BACKOFF;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {{(OUT_TDATA_W - OUT_GRAD_W - 3){1'b0}}, cdg_r, back_r, g_sat};
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide step");

  a_tail_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr |=> (tail_r != $past(tail_r)))
    else $error("ring write did not advance the tail");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_backoff_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[OUT_GRAD_W]) |->
      (out_data_r[OUT_GRAD_W+2:OUT_GRAD_W+1] == QS_BACKOFF))
    else $error("backoff result without backoff queue state");

endmodule
`default_nettype wire

### rtl/core/dgb_ring.sv
`default_nettype none
module dgb_ring #(
  parameter int WINDOW = dgb_pkg::WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(WINDOW)-1:0]  addr,
  input  wire dgb_pkg::grad_pair_t        wdata,
  output dgb_pkg::grad_pair_t             rdata
);
  import dgb_pkg::*;

  grad_pair_t mem_r [WINDOW];
  grad_pair_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/core/dgb_mul.sv
`default_nettype none
module dgb_mul #(
  parameter int A_W = dgb_pkg::MUL_A_W_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [A_W-1:0]                    a,
  input  wire logic [dgb_pkg::MUL_B_W-1:0]       b,
  output logic [A_W+dgb_pkg::MUL_B_W-1:0]        p
);
  import dgb_pkg::*;

  localparam int P_W = A_W + MUL_B_W;

  logic [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= P_W'(a) * P_W'(b);
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

### rtl/core/dgb_div.sv
`default_nettype none
module dgb_div #(
  parameter int NUM_W = dgb_pkg::NUM_W_DEF,
  parameter int DEN_W = dgb_pkg::LW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  dividend,
  input  wire logic [DEN_W-1:0]  divisor,
  output logic                   done,
  output logic [NUM_W-1:0]       quotient
);
  import dgb_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        quo_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= {quo_r[NUM_W-2:0], fits};
        rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire
